FILE: design/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4,
    CMD_LIST_FWD   = 3'd5,
    CMD_LIST_BWD   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

FILE: design/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded deque of signed 32-bit values in a ring store (DEPTH entries).
// Input channel: in_tuser carries the command, in_tdata the value to push.
// Result channel: out_tuser carries status, out_tdata the item (low word) and
// the back item (high word), out_tlast marks the final result of a command.
// One command is taken at a time; in_tready is high only while the sequencer
// is idle. A single ring-index adder (front pointer plus offset, wrapped by
// one compare and subtract) forms every store address but the front slot
// read by pop-front and peek, which comes straight from the front pointer.
// The store has one registered read port, so each entry read passes through
// the issue and load states. An empty or full condition gives its result
// without a store read. Command code 7 gives nothing.
// The result stays in the output register while out_tready is low; the next
// command or list entry is not started until the result transfer completes.
// Reset empties the deque (front pointer and count cleared) and returns the
// sequencer to idle; stored values are not cleared.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [2:0]          in_tuser,   // [2:0] cmd
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*DATA_W-1:0] out_tdata,  // [31:0] item, [63:32] back_item
  output logic [1:0]          out_tuser,  // [1:0] status
  output logic                out_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_LOAD  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]       off_r, off_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic                peek2_r, peek2_nxt;
  status_t             status_r, status_nxt;
  logic [DATA_W-1:0]   item_r, item_nxt;
  logic [DATA_W-1:0]   back_r, back_nxt;
  logic                last_r, last_nxt;

  logic [AW-1:0]       unit_off;
  logic [AW:0]         unit_sum;
  logic [AW-1:0]       slot;
  logic [AW-1:0]       off_step;
  logic [AW-1:0]       occ_m1;
  logic                full;
  logic                empty;
  logic                in_acc;
  cmd_t                in_cmd;

  logic                ram_we;
  logic [DATA_W-1:0]   ram_rdata;

  // shared ring-index unit
  assign unit_sum = {1'b0, front_r} + {1'b0, unit_off};
  assign slot     = (unit_sum >= (AW+1)'(DEPTH)) ? AW'(unit_sum - (AW+1)'(DEPTH))
                                                  : AW'(unit_sum);

  assign full     = (occ_r == CW'(DEPTH));
  assign empty    = (occ_r == '0);
  assign occ_m1   = AW'(occ_r - CW'(1));
  assign off_step = (cmd_r == CMD_LIST_BWD) ? off_r - AW'(1) : off_r + AW'(1);
  assign in_acc   = in_tvalid && in_tready;
  assign in_cmd   = cmd_t'(in_tuser);

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (in_tdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    occ_nxt     = occ_r;
    rd_addr_nxt = rd_addr_r;
    off_nxt     = off_r;
    rem_nxt     = rem_r;
    cmd_nxt     = cmd_r;
    peek2_nxt   = peek2_r;
    status_nxt  = status_r;
    item_nxt    = item_r;
    back_nxt    = back_r;
    last_nxt    = last_r;
    unit_off    = '0;
    ram_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        unique case (in_cmd)
          CMD_PUSH_FRONT: unit_off = AW'(DEPTH - 1);
          CMD_PUSH_BACK:  unit_off = AW'(occ_r);
          CMD_POP_FRONT:  unit_off = AW'(1);
          CMD_POP_BACK:   unit_off = occ_m1;
          CMD_LIST_BWD:   unit_off = occ_m1;
          default:        unit_off = '0;
        endcase
        if (in_acc && in_tuser != 3'd7) begin
          cmd_nxt    = in_cmd;
          peek2_nxt  = 1'b0;
          item_nxt   = '0;
          back_nxt   = '0;
          last_nxt   = 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          unique case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                occ_nxt = occ_r + CW'(1);
                if (in_cmd == CMD_PUSH_FRONT) begin
                  front_nxt = slot;
                end
              end
            end
            default: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_ISSUE;
                rd_addr_nxt = slot;
                if (in_cmd == CMD_POP_FRONT || in_cmd == CMD_PEEK) begin
                  rd_addr_nxt = front_r;
                end
                if (in_cmd == CMD_POP_FRONT) begin
                  front_nxt = slot;
                end
                if (in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_BACK) begin
                  occ_nxt = occ_r - CW'(1);
                end
                off_nxt = slot - front_r;
                if (in_cmd == CMD_LIST_FWD) begin
                  off_nxt = '0;
                end else if (in_cmd == CMD_LIST_BWD) begin
                  off_nxt = occ_m1;
                end
                rem_nxt = occ_r - CW'(1);
              end
            end
          endcase
        end
      end
      S_ISSUE: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        unit_off = occ_m1;
        if (cmd_r == CMD_PEEK && !peek2_r) begin
          item_nxt    = ram_rdata;
          peek2_nxt   = 1'b1;
          rd_addr_nxt = slot;
          state_nxt   = S_ISSUE;
        end else if (cmd_r == CMD_PEEK) begin
          back_nxt  = ram_rdata;
          state_nxt = S_OUT;
        end else begin
          item_nxt  = ram_rdata;
          last_nxt  = (cmd_r == CMD_LIST_FWD || cmd_r == CMD_LIST_BWD) ? (rem_r == '0)
                                                                       : 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        unit_off = off_step;
        if (out_tready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rem_nxt     = rem_r - CW'(1);
            off_nxt     = off_step;
            rd_addr_nxt = slot;
            state_nxt   = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
    rd_addr_r <= rd_addr_nxt;
    off_r     <= off_nxt;
    rem_r     <= rem_nxt;
    cmd_r     <= cmd_nxt;
    peek2_r   <= peek2_nxt;
    status_r  <= status_nxt;
    item_r    <= item_nxt;
    back_r    <= back_nxt;
    last_r    <= last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {back_r, item_r};
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK) && !full)
    |=> occ_r == $past(occ_r) + CW'(1))
    else $error("push did not grow the deque");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> state_r == S_IDLE)
    else $error("sequencer busy after final result");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> state_r == S_ISSUE)
    else $error("list stopped before its final entry");

endmodule

FILE: sim/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb
  import deq_pkg::*;
;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 23;
  localparam int N_DIRECTED  = 24;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    status_t     status;
    logic [31:0] item;
    logic [31:0] back_item;
    logic        last;
  } deque_result_t;

  typedef struct {
    logic [2:0]    cmd;
    logic [31:0]   value;
    int            reps;
    bit            typed;
    deque_result_t want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;
  logic [2:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [2*DATA_W-1:0] out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;

  // shadow deque
  logic [31:0] shadow_vals [DEPTH];
  int          shadow_head;
  int          shadow_count;

  deque_result_t expected_results [$];
  stim_row_t     directed [N_DIRECTED];

  // attached to the item currently offered
  bit            row_typed;
  deque_result_t row_want;

  int idle_pct;
  int stall_pct;
  bit pressure_on;
  int fail_count;
  int cycles;
  int commands_done;
  int results_checked;
  int full_hits;
  int empty_hits;
  int max_list;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void expect_result(status_t st, logic [31:0] item, logic [31:0] back,
                                        logic last);
    deque_result_t r;
    r.status    = st;
    r.item      = item;
    r.back_item = back;
    r.last      = last;
    expected_results.push_back(r);
    if (st == ST_FULL) full_hits++;
    if (st == ST_EMPTY) empty_hits++;
  endfunction

  function automatic void deque_apply(logic [2:0] cmd, logic [31:0] value);
    int pos;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          expect_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_vals[shadow_head] = value;
          end else begin
            shadow_vals[(shadow_head + shadow_count) % DEPTH] = value;
          end
          shadow_count++;
          expect_result(ST_OK, '0, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          expect_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            pos = shadow_head;
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            pos = (shadow_head + shadow_count - 1) % DEPTH;
          end
          shadow_count--;
          expect_result(ST_OK, shadow_vals[pos], '0, 1'b1);
        end
      end
      CMD_PEEK: begin
        if (shadow_count == 0)
          expect_result(ST_EMPTY, '0, '0, 1'b1);
        else
          expect_result(ST_OK, shadow_vals[shadow_head],
                        shadow_vals[(shadow_head + shadow_count - 1) % DEPTH], 1'b1);
      end
      CMD_LIST_FWD, CMD_LIST_BWD: begin
        if (shadow_count == 0) begin
          expect_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          if (shadow_count > max_list) max_list = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (cmd == CMD_LIST_FWD)
              pos = (shadow_head + i) % DEPTH;
            else
              pos = (shadow_head + shadow_count - 1 - i) % DEPTH;
            expect_result(ST_OK, shadow_vals[pos], '0, i == shadow_count - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result check first, then prediction for the transfer at the same edge
  always @(posedge clk) begin : scoreboard
    deque_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d item %h back_item %h last %0b",
                 out_tuser, out_tdata[31:0], out_tdata[63:32], out_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[31:0] !== want.item) begin
            $error("item mismatch: expected %h, got %h", want.item, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[63:32] !== want.back_item) begin
            $error("back_item mismatch: expected %h, got %h", want.back_item,
                   out_tdata[63:32]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        commands_done++;
        deque_apply(in_tuser, in_tdata);
        if (row_typed) expected_results[$] = row_want;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off under pressure
  initial begin : receiver
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (pressure_on && !held) begin
        held = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer(logic [2:0] cmd, logic [31:0] value, bit typed, deque_result_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(int idle, int stall, bit hold);
    int          sent;
    int          r;
    bit          fill_bias;
    logic [2:0]  cmd;
    logic [31:0] value;
    deque_result_t none;
    none = '{ST_OK, '0, '0, 1'b0};
    idle_pct    = idle;
    stall_pct   = stall;
    pressure_on = hold;
    sent        = 0;
    fill_bias   = $urandom_range(0, 1);
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 11) == 0) fill_bias = ~fill_bias;
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = 32'h0000_0000;
        3:       value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      r = $urandom_range(0, 99);
      if (r < 3)
        cmd = CMD_UNUSED;
      else if (r < (fill_bias ? 63 : 25))
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (r < (fill_bias ? 80 : 75))
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      else if (r < 88)
        cmd = CMD_PEEK;
      else
        cmd = $urandom_range(0, 1) ? CMD_LIST_BWD : CMD_LIST_FWD;
      offer(cmd, value, 1'b0, none);
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  initial begin : stimulus
    deque_result_t none;
    none = '{ST_OK, '0, '0, 1'b0};

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    row_typed   = 1'b0;
    row_want    = none;
    idle_pct    = 0;
    stall_pct   = 0;
    pressure_on = 1'b0;
    fail_count  = 0;
    cycles      = 0;
    commands_done   = 0;
    results_checked = 0;
    full_hits   = 0;
    empty_hits  = 0;
    max_list    = 0;
    shadow_head  = 0;
    shadow_count = 0;
    for (int i = 0; i < DEPTH; i++) shadow_vals[i] = '0;

    directed = '{
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 1'b1}},
      '{CMD_POP_BACK,   32'hffff_ffff, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 1'b1}},
      '{CMD_PEEK,       32'h0000_0000, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 1'b1}},
      '{CMD_LIST_FWD,   32'h0000_0000, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 1'b1}},
      '{CMD_LIST_BWD,   32'h0000_0000, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 1'b1}},
      '{CMD_UNUSED,     32'h1234_5678, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, '{ST_OK,    32'h0, 32'h0, 1'b1}},
      '{CMD_PUSH_BACK,  32'h7fff_ffff, 1,  1'b1, '{ST_OK,    32'h0, 32'h0, 1'b1}},
      '{CMD_PEEK,       32'h0000_0000, 1,  1'b1,
        '{ST_OK, 32'h8000_0000, 32'h7fff_ffff, 1'b1}},
      '{CMD_LIST_FWD,   32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_LIST_BWD,   32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_PUSH_FRONT, 32'hffff_ffff, 1,  1'b1, '{ST_OK,    32'h0, 32'h0, 1'b1}},
      '{CMD_PUSH_BACK,  32'h0000_0000, 1,  1'b1, '{ST_OK,    32'h0, 32'h0, 1'b1}},
      '{CMD_PUSH_BACK,  32'h5a5a_0001, 12, 1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_PUSH_FRONT, 32'h0bad_cafe, 1,  1'b1, '{ST_FULL,  32'h0, 32'h0, 1'b1}},
      '{CMD_PUSH_BACK,  32'hdead_beef, 1,  1'b1, '{ST_FULL,  32'h0, 32'h0, 1'b1}},
      '{CMD_LIST_FWD,   32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_LIST_BWD,   32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_PEEK,       32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b1,
        '{ST_OK, 32'hffff_ffff, 32'h0, 1'b1}},
      '{CMD_POP_BACK,   32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_UNUSED,     32'hffff_ffff, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}},
      '{CMD_LIST_FWD,   32'h0000_0000, 1,  1'b0, '{ST_OK,    32'h0, 32'h0, 1'b0}}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      for (int k = 0; k < directed[i].reps; k++)
        offer(directed[i].cmd, directed[i].value + k, directed[i].typed, directed[i].want);

    random_phase(0, 0, 1'b0);
    random_phase(53, 0, 1'b0);
    random_phase(0, 53, 1'b0);
    random_phase(29, 29, 1'b0);
    random_phase(0, 0, 1'b1);

    in_tvalid <= 1'b0;
    row_typed = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d commands, checked %0d results in %0d cycles.", commands_done,
             results_checked, cycles);
    $display("Full rejections %0d, empty reports %0d, longest listing %0d of %0d entries.",
             full_hits, empty_hits, max_list, DEPTH);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
sim/double_ended_queue_tb.sv
